FILE: src/scrm_pkg.sv
// ----------------------------------------------------------------------------
// scrm_pkg
// Shared types and arithmetic helpers for the sparse complex row product.
// ----------------------------------------------------------------------------
package scrm_pkg;

	// Configuration register indexes
	localparam logic [0:0] REG_B_COLS = 1'b0;
	localparam logic [0:0] REG_B_ROWS = 1'b1;

	// Input item kinds
	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_A     = 2'd1,
		KIND_END   = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic latch_in;
		logic load_b;
		logic clear_b;
		logic walk_init;
		logic prod;
		logic sum;
		logic acc_wr;
		logic next_j;
		logic scan_init;
		logic scan_step;
		logic emit_err;
		logic emit_empty;
		logic emit_col;
		logic row_done;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		kind_t kind;
		logic  load_bad;
		logic  a_bad;
		logic  j_done;
		logic  skip;
		logic  touched_any;
		logic  cur_touched;
		logic  col_last;
		logic  out_free;
	} stat_t;

	// Signed 64-bit add, clamped to the 64-bit range
	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		begin
			s = {a[63], a} + {b[63], b};
			if (s[64] != s[63]) begin
				sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
			end else begin
				sat_add = s[63:0];
			end
		end
	endfunction

endpackage

FILE: src/sparse_complex_row_matmul.sv
// ----------------------------------------------------------------------------
// sparse_complex_row_matmul
// Row-wise sparse complex matrix product with a sparse accumulator.
// ----------------------------------------------------------------------------
// Load and clear pass through the idle and decode states; an A entry adds a
// row table read and then walks its B row one entry at a time: B read,
// multiply, sum and accumulator read-modify-write (an entry outside the column
// count is skipped after the B read). End of row scans the columns up to the
// last marked one and emits each result. One request is in work at a time.
// Reset clears control state only: no clearing pass; the B store is undefined.
module sparse_complex_row_matmul #(
	parameter int MAX_COLS       = 64,
	parameter int MAX_INNER      = 64,
	parameter int MAX_B_NONZEROS = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [79:0]  s_axis_tdata,  // b_row, col, value_re, value_im
	input  logic [1:0]   s_axis_tuser,  // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [151:0] m_axis_tdata,  // out_row, out_col, sum_re, sum_im
	output logic [1:0]   m_axis_tuser,  // empty_row, error
	output logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic         cfg_addr,
	input  logic [6:0]   cfg_wdata
);

	scrm_pkg::cmd_t  cmd;
	scrm_pkg::stat_t stat;

	logic [15:0]        out_row;
	logic [5:0]         out_col;
	logic signed [63:0] sum_re, sum_im;
	logic               empty_row, error;

	scrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	scrm_dp #(
		.MAX_COLS       (MAX_COLS),
		.MAX_INNER      (MAX_INNER),
		.MAX_B_NONZEROS (MAX_B_NONZEROS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_kind   (s_axis_tuser),
		.in_b_row  (s_axis_tdata[5:0]),
		.in_col    (s_axis_tdata[11:6]),
		.in_re     (s_axis_tdata[43:12]),
		.in_im     (s_axis_tdata[75:44]),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_re    (sum_re),
		.out_im    (sum_im),
		.out_empty (empty_row),
		.out_error (error),
		.out_last  (m_axis_tlast)
	);

	// Pack the result fields
	assign m_axis_tdata = {2'b00, sum_im, sum_re, out_col, out_row};
	assign m_axis_tuser = {error, empty_row};

endmodule

FILE: src/scrm_ctrl.sv
// ----------------------------------------------------------------------------
// scrm_ctrl
// Sequencer: decodes each request, walks a B row, scans the accumulators.
// ----------------------------------------------------------------------------
module scrm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  scrm_pkg::stat_t stat,
	output scrm_pkg::cmd_t  cmd
);

	typedef enum logic [10:0] {
		ST_IDLE     = 11'b00000000001,
		ST_DECODE   = 11'b00000000010,
		ST_ROW_RD   = 11'b00000000100,
		ST_WALK     = 11'b00000001000,
		ST_B_CHK    = 11'b00000010000,
		ST_SUM      = 11'b00000100000,
		ST_ACC      = 11'b00001000000,
		ST_SCAN     = 11'b00010000000,
		ST_SCAN_OUT = 11'b00100000000,
		ST_ERR      = 11'b01000000000,
		ST_EMPTY    = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (stat.kind)
					scrm_pkg::KIND_LOAD: begin
						if (stat.load_bad) begin
							state_d = ST_ERR;
						end else begin
							cmd.load_b = 1'b1;
							state_d    = ST_IDLE;
						end
					end
					scrm_pkg::KIND_A: begin
						state_d = stat.a_bad ? ST_ERR : ST_ROW_RD;
					end
					scrm_pkg::KIND_END: begin
						if (stat.touched_any) begin
							cmd.scan_init = 1'b1;
							state_d       = ST_SCAN;
						end else begin
							state_d = ST_EMPTY;
						end
					end
					default: begin
						cmd.clear_b = 1'b1;
						state_d     = ST_IDLE;
					end
				endcase
			end
			ST_ROW_RD: begin
				cmd.walk_init = 1'b1;
				state_d       = ST_WALK;
			end
			ST_WALK: begin
				state_d = stat.j_done ? ST_IDLE : ST_B_CHK;
			end
			ST_B_CHK: begin
				if (stat.skip) begin
					cmd.next_j = 1'b1;
					state_d    = ST_WALK;
				end else begin
					cmd.prod = 1'b1;
					state_d  = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_wr = 1'b1;
				cmd.next_j = 1'b1;
				state_d    = ST_WALK;
			end
			ST_SCAN: begin
				if (stat.cur_touched) begin
					state_d = ST_SCAN_OUT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_SCAN_OUT: begin
				if (stat.out_free) begin
					cmd.emit_col = 1'b1;
					if (stat.col_last) begin
						cmd.row_done = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						cmd.scan_step = 1'b1;
						state_d       = ST_SCAN;
					end
				end
			end
			ST_ERR: begin
				if (stat.out_free) begin
					cmd.emit_err = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				if (stat.out_free) begin
					cmd.emit_empty = 1'b1;
					cmd.row_done   = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: src/scrm_dp.sv
// ----------------------------------------------------------------------------
// scrm_dp
// Datapath: B store, row table, complex multiply, accumulators, result reg.
// ----------------------------------------------------------------------------
module scrm_dp #(
	parameter int MAX_COLS       = 64,
	parameter int MAX_INNER      = 64,
	parameter int MAX_B_NONZEROS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  scrm_pkg::cmd_t     cmd,
	output scrm_pkg::stat_t    stat,
	input  logic [1:0]         in_kind,
	input  logic [5:0]         in_b_row,
	input  logic [5:0]         in_col,
	input  logic signed [31:0] in_re,
	input  logic signed [31:0] in_im,
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [6:0]         cfg_wdata,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [15:0]        out_row,
	output logic [5:0]         out_col,
	output logic signed [63:0] out_re,
	output logic signed [63:0] out_im,
	output logic               out_empty,
	output logic               out_error,
	output logic               out_last
);

	localparam int RT     = (MAX_INNER < 64) ? MAX_INNER : 64;
	localparam int ROW_W  = $clog2(RT);
	localparam int IDX_W  = $clog2(MAX_B_NONZEROS);
	localparam int NZ_W   = $clog2(MAX_B_NONZEROS + 1);
	localparam int CIDX_W = $clog2(MAX_COLS);

	// Latched request
	scrm_pkg::kind_t    kind_q;
	logic [5:0]         brow_q, col_q;
	logic signed [31:0] vr_q, vi_q;

	// Configuration
	logic [6:0] b_cols_q, b_rows_q;

	// B store bookkeeping
	logic [NZ_W-1:0]   fill_q, cur_begin_q, j_q, end_q;
	logic [5:0]        last_row_q;
	logic [RT-1:0]     row_vld_q;
	logic [2*NZ_W-1:0] row_mem [RT];
	logic [2*NZ_W-1:0] row_rd_q;
	logic              row_vld_rd_q;
	logic [69:0]       b_mem [MAX_B_NONZEROS];
	logic [69:0]       b_rd_q;

	// Products and sums
	logic signed [63:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [63:0] pr_s2, pi_s2;

	// Accumulators
	logic [127:0]        acc_mem [MAX_COLS];
	logic [127:0]        acc_rd_q;
	logic [MAX_COLS-1:0] touched_q;
	logic [CIDX_W-1:0]   scan_c_q;
	logic [15:0]         row_cnt_q;

	logic [ROW_W-1:0]   load_addr, rd_addr;
	logic [5:0]         bcol;
	logic [CIDX_W-1:0]  bidx, acc_addr;
	logic               new_row;
	logic [NZ_W-1:0]    begin_new, fill_inc;
	logic signed [63:0] acc_re_rd, acc_im_rd, nre, nim;

	assign load_addr = brow_q[ROW_W-1:0];
	assign rd_addr   = col_q[ROW_W-1:0];
	assign bcol      = b_rd_q[69:64];
	assign bidx      = bcol[CIDX_W-1:0];
	assign acc_addr  = cmd.sum ? bidx : scan_c_q;
	assign new_row   = (fill_q == '0) || (brow_q != last_row_q);
	assign begin_new = new_row ? fill_q : cur_begin_q;
	assign fill_inc  = fill_q + NZ_W'(1);
	assign acc_re_rd = acc_rd_q[127:64];
	assign acc_im_rd = acc_rd_q[63:0];
	assign nre = touched_q[bidx] ? scrm_pkg::sat_add(acc_re_rd, pr_s2) : pr_s2;
	assign nim = touched_q[bidx] ? scrm_pkg::sat_add(acc_im_rd, pi_s2) : pi_s2;

	// Status toward the controller
	always_comb begin
		stat.kind     = kind_q;
		stat.load_bad = ({1'b0, brow_q} >= b_rows_q) || (11'(brow_q) >= 11'(MAX_INNER)) ||
			({1'b0, col_q} >= b_cols_q) || ({1'b0, col_q} >= 7'(MAX_COLS)) ||
			(fill_q == NZ_W'(MAX_B_NONZEROS)) || (brow_q < last_row_q);
		stat.a_bad    = ({1'b0, col_q} >= b_rows_q) || (11'(col_q) >= 11'(MAX_INNER));
		stat.j_done   = (j_q >= end_q);
		stat.skip     = ({1'b0, bcol} >= b_cols_q) || ({1'b0, bcol} >= 7'(MAX_COLS));
		stat.touched_any = |touched_q;
		stat.cur_touched = touched_q[scan_c_q];
		stat.col_last    = (touched_q & ~(MAX_COLS'(1) << scan_c_q)) == '0;
		stat.out_free    = !out_valid || out_ready;
	end

	// Latch the request
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			kind_q <= scrm_pkg::kind_t'(in_kind);
			brow_q <= in_b_row;
			col_q  <= in_col;
			vr_q   <= in_re;
			vi_q   <= in_im;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_cols_q <= 7'd64;
			b_rows_q <= 7'd64;
		end else if (cfg_we) begin
			if (cfg_addr == scrm_pkg::REG_B_COLS) begin
				b_cols_q <= cfg_wdata;
			end else begin
				b_rows_q <= cfg_wdata;
			end
		end
	end

	// B store control: fill count, last row, row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			last_row_q <= '0;
			row_vld_q  <= '0;
		end else if (cmd.clear_b) begin
			fill_q     <= '0;
			last_row_q <= '0;
			row_vld_q  <= '0;
		end else if (cmd.load_b) begin
			fill_q               <= fill_inc;
			last_row_q           <= brow_q;
			row_vld_q[load_addr] <= 1'b1;
		end
	end

	// Row table and B entry memories
	always_ff @(posedge clk) begin
		if (cmd.load_b) begin
			row_mem[load_addr]      <= {begin_new, fill_inc};
			cur_begin_q             <= begin_new;
			b_mem[fill_q[IDX_W-1:0]] <= {col_q, vr_q, vi_q};
		end
		row_rd_q     <= row_mem[rd_addr];
		row_vld_rd_q <= row_vld_q[rd_addr];
		b_rd_q       <= b_mem[j_q[IDX_W-1:0]];
	end

	// Walk pointer over one B row
	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			j_q   <= row_vld_rd_q ? row_rd_q[2*NZ_W-1:NZ_W] : '0;
			end_q <= row_vld_rd_q ? row_rd_q[NZ_W-1:0] : '0;
		end else if (cmd.next_j) begin
			j_q <= j_q + NZ_W'(1);
		end
	end

	// Complex multiply: four products, then the two saturating sums
	always_ff @(posedge clk) begin
		if (cmd.prod) begin
			p_rr_s1 <= vr_q * $signed(b_rd_q[63:32]);
			p_ii_s1 <= vi_q * $signed(b_rd_q[31:0]);
			p_ri_s1 <= vr_q * $signed(b_rd_q[31:0]);
			p_ir_s1 <= vi_q * $signed(b_rd_q[63:32]);
		end
		if (cmd.sum) begin
			pr_s2 <= scrm_pkg::sat_add(p_rr_s1, -p_ii_s1);
			pi_s2 <= scrm_pkg::sat_add(p_ri_s1, p_ir_s1);
		end
	end

	// Accumulator memory
	always_ff @(posedge clk) begin
		if (cmd.acc_wr) begin
			acc_mem[bidx] <= {nre, nim};
		end
		acc_rd_q <= acc_mem[acc_addr];
	end

	// Column marks, scan pointer and row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touched_q <= '0;
			scan_c_q  <= '0;
			row_cnt_q <= '0;
		end else begin
			if (cmd.acc_wr) begin
				touched_q[bidx] <= 1'b1;
			end else if (cmd.emit_col) begin
				touched_q[scan_c_q] <= 1'b0;
			end
			if (cmd.scan_init) begin
				scan_c_q <= '0;
			end else if (cmd.scan_step) begin
				scan_c_q <= scan_c_q + CIDX_W'(1);
			end
			if (cmd.row_done) begin
				row_cnt_q <= row_cnt_q + 16'd1;
			end
		end
	end

	// Result register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit_err || cmd.emit_empty || cmd.emit_col) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err || cmd.emit_empty || cmd.emit_col) begin
			out_row   <= row_cnt_q;
			out_col   <= cmd.emit_col ? 6'(scan_c_q) : 6'd0;
			out_re    <= cmd.emit_col ? acc_re_rd : 64'sd0;
			out_im    <= cmd.emit_col ? acc_im_rd : 64'sd0;
			out_empty <= cmd.emit_empty;
			out_error <= cmd.emit_err;
			out_last  <= cmd.emit_col ? stat.col_last : 1'b1;
		end
	end

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= NZ_W'(MAX_B_NONZEROS))
		else $error("B fill count beyond store depth");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_err || cmd.emit_empty || cmd.emit_col) |-> stat.out_free)
		else $error("result emitted into an occupied register");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_col && stat.col_last) |=> (touched_q == '0))
		else $error("column marks left after the last result of a row");
	a_acc_marks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc_wr |=> (touched_q != '0))
		else $error("accumulate did not mark its column");
`endif

endmodule

FILE: sim/sparse_complex_row_matmul_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_complex_row_matmul_chk
// Watches the request, result and register ports of the sparse complex row
// product, keeps its own model of the B store and the row accumulators,
// queues the results each accepted request should give and compares every
// accepted result, field by field, against the oldest one queued.
// ----------------------------------------------------------------------------
module sparse_complex_row_matmul_chk #(
	parameter int MAX_COLS       = 64,
	parameter int MAX_INNER      = 64,
	parameter int MAX_B_NONZEROS = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [79:0]  s_axis_tdata,  // b_row, col, value_re, value_im
	input  logic [1:0]   s_axis_tuser,  // kind
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [151:0] m_axis_tdata,  // out_row, out_col, sum_re, sum_im
	input  logic [1:0]   m_axis_tuser,  // empty_row, error
	input  logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic         cfg_addr,
	input  logic [6:0]   cfg_wdata,
	output int           fail_count,
	output int           pending
);

	typedef struct {
		logic [15:0]        row;
		logic [5:0]         col;
		logic signed [63:0] re;
		logic signed [63:0] im;
		logic               empty;
		logic               err;
		logic               last;
	} entry_t;

	entry_t exp_results[$];

	// Model state: B store with row ranges, accumulators and marks
	logic [5:0]         b_col_mem [MAX_B_NONZEROS];
	logic signed [31:0] b_re_mem  [MAX_B_NONZEROS];
	logic signed [31:0] b_im_mem  [MAX_B_NONZEROS];
	int                 row_first [MAX_INNER];
	int                 row_stop  [MAX_INNER];
	int                 fill;
	int                 prev_row;
	logic signed [63:0] acc_re    [MAX_COLS];
	logic signed [63:0] acc_im    [MAX_COLS];
	bit                 marked    [MAX_COLS];
	logic [15:0]        row_idx;
	int                 n_cols;
	int                 n_rows;

	assign pending = exp_results.size();

	function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63])
			r = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return r;
	endfunction

	task automatic push(input logic [5:0] c, input logic signed [63:0] re,
		input logic signed [63:0] im, input logic empty, input logic err,
		input logic last);
		entry_t e;
		e.row = row_idx;
		e.col = c;
		e.re = re;
		e.im = im;
		e.empty = empty;
		e.err = err;
		e.last = last;
		exp_results = {exp_results, e};
	endtask

	task automatic report(input string what, input logic [151:0] got,
		input logic [151:0] want);
		$display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
		fail_count++;
	endtask

	// Work out the results of one accepted request and update the model
	task automatic predict(input scrm_pkg::kind_t kind, input int brow, input int k,
		input logic signed [31:0] vr, input logic signed [31:0] vi);
		int                 eff;
		int                 r;
		int                 c;
		int                 n;
		logic signed [63:0] pr;
		logic signed [63:0] pi;
		eff = (n_cols < MAX_COLS) ? n_cols : MAX_COLS;
		case (kind)
			scrm_pkg::KIND_LOAD: begin
				if (brow >= n_rows || brow >= MAX_INNER || k >= eff ||
						fill >= MAX_B_NONZEROS || brow < prev_row) begin
					push(0, 0, 0, 0, 1, 1);
				end else begin
					// Give every skipped row an empty range
					if (brow > prev_row || fill == 0) begin
						for (r = (fill == 0) ? 0 : prev_row + 1; r <= brow; r++) begin
							row_first[r] = fill;
							row_stop[r] = fill;
						end
					end
					b_col_mem[fill] = 6'(k);
					b_re_mem[fill] = vr;
					b_im_mem[fill] = vi;
					fill++;
					row_stop[brow] = fill;
					prev_row = brow;
				end
			end
			scrm_pkg::KIND_A: begin
				if (k >= n_rows || k >= MAX_INNER) begin
					push(0, 0, 0, 0, 1, 1);
				end else begin
					// Scale B row k into the accumulators, skip narrowed columns
					for (r = row_first[k]; r < row_stop[k]; r++) begin
						c = b_col_mem[r];
						if (c < eff) begin
							pr = clamp_add(longint'(vr) * longint'(b_re_mem[r]),
								-(longint'(vi) * longint'(b_im_mem[r])));
							pi = clamp_add(longint'(vr) * longint'(b_im_mem[r]),
								longint'(vi) * longint'(b_re_mem[r]));
							if (!marked[c]) begin
								marked[c] = 1'b1;
								acc_re[c] = pr;
								acc_im[c] = pi;
							end else begin
								acc_re[c] = clamp_add(acc_re[c], pr);
								acc_im[c] = clamp_add(acc_im[c], pi);
							end
						end
					end
				end
			end
			scrm_pkg::KIND_END: begin
				n = 0;
				for (c = 0; c < MAX_COLS; c++) begin
					if (marked[c]) begin
						push(6'(c), acc_re[c], acc_im[c], 0, 0, 0);
						marked[c] = 1'b0;
						n++;
					end
				end
				if (n == 0)
					push(0, 0, 0, 1, 0, 1);
				else
					exp_results[$].last = 1'b1;
				row_idx++;
			end
			default: begin
				fill = 0;
				prev_row = 0;
				for (r = 0; r < MAX_INNER; r++) begin
					row_first[r] = 0;
					row_stop[r] = 0;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		entry_t e;
		if (!arst_n) begin
			for (int i = 0; i < MAX_INNER; i++) begin
				row_first[i] = 0;
				row_stop[i] = 0;
			end
			for (int i = 0; i < MAX_COLS; i++)
				marked[i] = 1'b0;
			fill = 0;
			prev_row = 0;
			row_idx = 0;
			n_cols = 64;
			n_rows = 64;
			fail_count = 0;
			exp_results.delete();
		end else begin
			// Track register writes
			if (cfg_we) begin
				if (cfg_addr == scrm_pkg::REG_B_COLS)
					n_cols = cfg_wdata;
				else if (cfg_addr == scrm_pkg::REG_B_ROWS)
					n_rows = cfg_wdata;
			end
			// Predict each accepted request
			if (s_axis_tvalid && s_axis_tready)
				predict(scrm_pkg::kind_t'(s_axis_tuser), s_axis_tdata[5:0],
					s_axis_tdata[11:6], s_axis_tdata[43:12], s_axis_tdata[75:44]);
			// Compare each accepted result with the oldest expectation
			if (m_axis_tvalid && m_axis_tready) begin
				if (exp_results.size() == 0) begin
					report("unexpected result", m_axis_tdata, 0);
				end else begin
					e = exp_results.pop_front();
					if (m_axis_tdata[15:0] !== e.row)
						report("out_row", m_axis_tdata[15:0], e.row);
					if (m_axis_tdata[21:16] !== e.col)
						report("out_col", m_axis_tdata[21:16], e.col);
					if (m_axis_tdata[85:22] !== e.re)
						report("sum_re", m_axis_tdata[85:22], e.re);
					if (m_axis_tdata[149:86] !== e.im)
						report("sum_im", m_axis_tdata[149:86], e.im);
					if (m_axis_tuser[0] !== e.empty)
						report("empty_row", m_axis_tuser[0], e.empty);
					if (m_axis_tuser[1] !== e.err)
						report("error", m_axis_tuser[1], e.err);
					if (m_axis_tlast !== e.last)
						report("last", m_axis_tlast, e.last);
				end
			end
		end
	end

endmodule

FILE: sim/sparse_complex_row_matmul_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_complex_row_matmul_tb
// Drives the sparse complex row product with directed and random B loads,
// A rows, clears and register settings under bursty requests and a stalling
// result side; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module sparse_complex_row_matmul_tb;

	localparam int LIMIT = 3000000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [79:0]  s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [151:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;
	logic         cfg_we;
	logic         cfg_addr;
	logic [6:0]   cfg_wdata;
	int           fail_count;
	int           pending;
	int           cycles = 0;
	int           burst_left;
	int           hold_cnt;
	int           stall_mode;
	int           mode_cnt;
	logic         hold_req;
	int           cur_rows;
	int           cur_cols;
	int           sent;

	sparse_complex_row_matmul dut (.*);

	sparse_complex_row_matmul_chk chk (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Give up after a generous number of cycles
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Stall the result side on a changing pattern; hold off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_cnt <= 0;
			stall_mode <= 0;
			mode_cnt <= 0;
		end else begin
			mode_cnt <= mode_cnt + 1;
			if (mode_cnt % 97 == 0)
				stall_mode <= $urandom_range(0, 2);
			if (hold_req) begin
				hold_cnt <= 400;
				m_axis_tready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				m_axis_tready <= 1'b0;
			end else begin
				case (stall_mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= $urandom_range(0, 1);
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 6))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return 32'(signed'($urandom_range(0, 262143)) - 131072);
			default: return $urandom;
		endcase
	endfunction

	// Offer one request in bursts with random gaps; return once accepted
	task automatic send(input scrm_pkg::kind_t kind, input int brow, input int k,
		input logic [31:0] vr, input logic [31:0] vi);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		sent++;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {4'd0, vi, vr, 6'(k), 6'(brow)};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Close the row so the block goes idle, then wait for every result
	task automatic flush();
		send(scrm_pkg::KIND_END, 0, 0, 0, 0);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input int val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= 7'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == scrm_pkg::REG_B_COLS)
			cur_cols = val;
		else
			cur_rows = val;
	endtask

	// Load a B matrix row by row with skipped rows and some bad loads
	task automatic load_b();
		int r;
		int n;
		r = $urandom_range(0, 2);
		while (r < cur_rows && r < 64) begin
			n = $urandom_range(0, 4);
			repeat (n) begin
				case ($urandom_range(0, 15))
					0: send(scrm_pkg::KIND_LOAD, $urandom_range(0, 63),
						$urandom_range(0, 63), pick_value(), pick_value());
					1: if (r > 0)
						send(scrm_pkg::KIND_LOAD, r - 1, 0, pick_value(), pick_value());
					default: send(scrm_pkg::KIND_LOAD, r, $urandom_range(0, cur_cols - 1),
						pick_value(), pick_value());
				endcase
			end
			r += $urandom_range(1, 3);
		end
	endtask

	// Several A rows with random entries, a few with bad inner indexes
	task automatic a_rows();
		repeat ($urandom_range(3, 7)) begin
			repeat ($urandom_range(0, 5)) begin
				if ($urandom_range(0, 11) == 0)
					send(scrm_pkg::KIND_A, 0, $urandom_range(0, 63), pick_value(),
						pick_value());
				else
					send(scrm_pkg::KIND_A, 0, $urandom_range(0, cur_rows - 1),
						pick_value(), pick_value());
			end
			send(scrm_pkg::KIND_END, 0, 0, 0, 0);
		end
	endtask

	initial begin
		int ph;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = scrm_pkg::KIND_LOAD;
		cfg_we = 1'b0;
		cfg_addr = scrm_pkg::REG_B_COLS;
		cfg_wdata = '0;
		hold_req = 1'b0;
		burst_left = 0;
		sent = 0;
		cur_rows = 64;
		cur_cols = 64;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, skipped rows, saturation, order and range errors
		send(scrm_pkg::KIND_CLEAR, 0, 0, 0, 0);
		send(scrm_pkg::KIND_LOAD, 0, 0, 32'h7fff_ffff, 32'h8000_0000);
		send(scrm_pkg::KIND_LOAD, 0, 63, 32'h8000_0000, 32'h7fff_ffff);
		send(scrm_pkg::KIND_LOAD, 5, 1, 32'hffff_ffff, 32'h0001_0000);
		send(scrm_pkg::KIND_LOAD, 63, 63, 32'h0, 32'hffff_ffff);
		send(scrm_pkg::KIND_LOAD, 2, 3, 32'h1, 32'h1);
		send(scrm_pkg::KIND_A, 0, 0, 32'h7fff_ffff, 32'h8000_0000);
		send(scrm_pkg::KIND_A, 0, 0, 32'h7fff_ffff, 32'h8000_0000);
		send(scrm_pkg::KIND_A, 0, 5, 32'h8000_0000, 32'h8000_0000);
		send(scrm_pkg::KIND_A, 0, 3, 32'h0001_0000, 32'h0);
		send(scrm_pkg::KIND_A, 0, 63, 32'hffff_ffff, 32'h7fff_ffff);
		send(scrm_pkg::KIND_END, 0, 0, 0, 0);
		send(scrm_pkg::KIND_A, 0, 3, 32'h0001_0000, 32'h0);
		send(scrm_pkg::KIND_END, 0, 0, 0, 0);
		flush();
		write_reg(scrm_pkg::REG_B_ROWS, 1);
		write_reg(scrm_pkg::REG_B_COLS, 1);
		send(scrm_pkg::KIND_A, 0, 1, 32'h1, 32'h1);
		send(scrm_pkg::KIND_LOAD, 1, 0, 32'h1, 32'h1);
		send(scrm_pkg::KIND_LOAD, 0, 1, 32'h1, 32'h1);
		send(scrm_pkg::KIND_CLEAR, 0, 0, 0, 0);
		send(scrm_pkg::KIND_LOAD, 0, 0, 32'h0002_0000, 32'hfffe_0000);
		send(scrm_pkg::KIND_A, 0, 0, 32'h0003_0000, 32'h0001_0000);
		send(scrm_pkg::KIND_A, 0, 0, 32'h0003_0000, 32'h0001_0000);
		flush();

		// Random phases under several register settings
		ph = 0;
		while (sent < 150) begin
			case (ph % 4)
				0: begin write_reg(scrm_pkg::REG_B_COLS, 64);
					write_reg(scrm_pkg::REG_B_ROWS, 64); end
				1: begin write_reg(scrm_pkg::REG_B_COLS, $urandom_range(1, 64));
					write_reg(scrm_pkg::REG_B_ROWS, $urandom_range(1, 64)); end
				2: begin write_reg(scrm_pkg::REG_B_COLS, 63);
					write_reg(scrm_pkg::REG_B_ROWS, 2); end
				default: begin write_reg(scrm_pkg::REG_B_COLS, $urandom_range(2, 64));
					write_reg(scrm_pkg::REG_B_ROWS, 64); end
			endcase
			send(scrm_pkg::KIND_CLEAR, 0, 0, 0, 0);
			load_b();
			// Narrow the column count after loading now and then
			if (ph % 3 == 1) begin
				flush();
				write_reg(scrm_pkg::REG_B_COLS, $urandom_range(1, cur_cols));
			end
			// Hold off the result side once while requests keep coming
			if (ph == 0) begin
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
			end
			a_rows();
			// Random noise of any kind
			repeat ($urandom_range(0, 4)) begin
				send(scrm_pkg::kind_t'($urandom_range(0, 3)), $urandom_range(0, 63),
					$urandom_range(0, 63), pick_value(), pick_value());
			end
			flush();
			ph++;
		end

		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
src/scrm_pkg.sv
src/scrm_ctrl.sv
src/scrm_dp.sv
src/sparse_complex_row_matmul.sv
sim/sparse_complex_row_matmul_chk.sv
sim/sparse_complex_row_matmul_tb.sv
